// ===== sv/pete_pkg.sv =====
`default_nettype none
package pete_pkg;
    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_TX     = 3'd1,
        MODE_RX     = 3'd2,
        MODE_QRX    = 3'd3,
        MODE_QTX    = 3'd4,
        MODE_NEWEST = 3'd5
    } mode_t;

    localparam logic [31:0] TIME_MAX = 32'hffffffff;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  seq;
        logic [31:0] phase_in;
        logic [31:0] partner_rx_phase;
        logic [31:0] partner_tx_phase;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  entry_index;
        logic [31:0] phase_out;
        logic [31:0] phi_aa_out;
        logic [31:0] phi_ab_out;
        logic [31:0] phi_ba_out;
        logic [31:0] phi_bb_out;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== sv/pete_if.sv =====
`default_nettype none
interface pete_in_if;
    logic              valid;
    logic              ready;
    pete_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pete_out_if;
    logic               valid;
    logic               ready;
    pete_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pete_cfg_if;
    logic valid;
    logic ready;
    logic is_master;
    modport source (output valid, output is_master, input ready);
    modport sink   (input valid, input is_master, output ready);
endinterface
`default_nettype wire

// ===== sv/pete_front.sv =====
`default_nettype none
// Two-entry queue in front of the table engine.
module pete_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    pete_in_if.sink                  in_ch,
    output pete_pkg::in_word_t       q_data,
    output logic                     q_valid,
    input  wire logic                q_pop
);
    import pete_pkg::*;

    in_word_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push    = in_ch.valid && in_ch.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule
`default_nettype wire

// ===== sv/pete_back.sv =====
`default_nettype none
// Table engine: scans one slot per cycle, then applies the update or answers the query.
module pete_back #(
    parameter int ENTRIES = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          is_master,
    input  pete_pkg::in_word_t q_data,
    input  wire logic          q_valid,
    output logic               q_pop,
    pete_out_if.source         out_ch,
    output logic               busy
);
    import pete_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic        valid_reg [ENTRIES];
    logic        comp_reg  [ENTRIES];
    logic [7:0]  seq_reg   [ENTRIES];
    logic [31:0] aa_reg    [ENTRIES];
    logic [31:0] ab_reg    [ENTRIES];
    logic [31:0] ba_reg    [ENTRIES];
    logic [31:0] bb_reg    [ENTRIES];
    logic [31:0] st_reg    [ENTRIES];
    logic [31:0] dt_reg    [ENTRIES];

    state_t     state_reg, state_next;
    in_word_t   it_reg;
    logic [IW:0] ptr_reg;
    logic [IW-1:0] p;
    // scan results
    logic        cur_f_reg, old_f_reg, free_f_reg, best_f_reg;
    logic [IW-1:0] cur_reg, old_reg, free_reg, oldest_reg, best_reg;
    logic [31:0] oldest_t_reg, best_t_reg;
    out_word_t   res_reg;
    logic        ovalid_reg;
    logic [7:0]  prev;

    assign p      = ptr_reg[IW-1:0];
    assign prev   = it_reg.seq - 8'd1;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = res_reg;
    assign busy   = (state_reg != ST_IDLE) || ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ptr_reg == (IW+1)'(ENTRIES - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            res_reg    <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                comp_reg[i]  <= 1'b0;
                seq_reg[i]   <= 8'd0;
                aa_reg[i]    <= 32'd0;
                ab_reg[i]    <= 32'd0;
                ba_reg[i]    <= 32'd0;
                bb_reg[i]    <= 32'd0;
                st_reg[i]    <= 32'd0;
                dt_reg[i]    <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == ST_APPLY)
            begin
                logic [IW-1:0] sp;
                out_word_t     res;
                sp  = free_f_reg ? free_reg : oldest_reg;
                res = '0;
                ovalid_reg <= 1'b1;
                unique case (it_reg.mode) inside
                    MODE_START, MODE_TX:
                    begin
                        if (it_reg.mode == MODE_START || is_master)
                        begin
                            res.hit         = 1'b1;
                            res.entry_index = 4'(sp);
                            valid_reg[sp] <= 1'b1;
                            comp_reg[sp]  <= 1'b0;
                            seq_reg[sp]   <= it_reg.seq;
                            aa_reg[sp]    <= (it_reg.mode == MODE_TX) ? it_reg.phase_in
                                                                      : 32'd0;
                            ab_reg[sp]    <= 32'd0;
                            ba_reg[sp]    <= 32'd0;
                            bb_reg[sp]    <= 32'd0;
                            st_reg[sp]    <= it_reg.now_ms;
                            dt_reg[sp]    <= 32'd0;
                        end
                        else if (cur_f_reg)
                        begin
                            res.hit         = 1'b1;
                            res.entry_index = 4'(cur_reg);
                            bb_reg[cur_reg] <= it_reg.phase_in;
                        end
                    end
                    MODE_RX:
                    begin
                        if (cur_f_reg)
                        begin
                            if (is_master)
                            begin
                                ba_reg[cur_reg] <= it_reg.phase_in;
                                ab_reg[cur_reg] <= it_reg.partner_rx_phase;
                            end
                            else
                            begin
                                ab_reg[cur_reg] <= it_reg.phase_in;
                            end
                        end
                        if (old_f_reg)
                        begin
                            if (is_master)
                            begin
                                bb_reg[old_reg] <= it_reg.partner_tx_phase;
                            end
                            else
                            begin
                                aa_reg[old_reg] <= it_reg.partner_tx_phase;
                                ba_reg[old_reg] <= it_reg.partner_rx_phase;
                            end
                            if (cur_f_reg)
                            begin
                                dt_reg[old_reg]   <= it_reg.now_ms;
                                comp_reg[old_reg] <= 1'b1;
                                res.hit         = 1'b1;
                                res.entry_index = 4'(old_reg);
                            end
                        end
                    end
                    MODE_QRX, MODE_QTX:
                    begin
                        if (cur_f_reg)
                        begin
                            res.hit         = 1'b1;
                            res.entry_index = 4'(cur_reg);
                            if (it_reg.mode == MODE_QRX)
                            begin
                                res.phase_out = is_master ? ba_reg[cur_reg]
                                                          : ab_reg[cur_reg];
                            end
                            else
                            begin
                                res.phase_out = is_master ? aa_reg[cur_reg]
                                                          : bb_reg[cur_reg];
                            end
                        end
                    end
                    MODE_NEWEST:
                    begin
                        if (best_f_reg)
                        begin
                            res.hit         = 1'b1;
                            res.entry_index = 4'(best_reg);
                            res.phi_aa_out  = aa_reg[best_reg];
                            res.phi_ab_out  = ab_reg[best_reg];
                            res.phi_ba_out  = ba_reg[best_reg];
                            res.phi_bb_out  = bb_reg[best_reg];
                        end
                    end
                    default: ;
                endcase
                res_reg <= res;
            end
        end
    end

    // scan datapath, one slot a cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            it_reg       <= q_data;
            ptr_reg      <= '0;
            cur_f_reg    <= 1'b0;
            old_f_reg    <= 1'b0;
            free_f_reg   <= 1'b0;
            best_f_reg   <= 1'b0;
            cur_reg      <= '0;
            old_reg      <= '0;
            free_reg     <= '0;
            oldest_reg   <= '0;
            best_reg     <= '0;
            oldest_t_reg <= TIME_MAX;
            best_t_reg   <= 32'd0;
        end
        else if (state_reg == ST_SCAN)
        begin
            ptr_reg <= ptr_reg + 1'b1;
            if (valid_reg[p] && seq_reg[p] == it_reg.seq && !cur_f_reg)
            begin
                cur_f_reg <= 1'b1;
                cur_reg   <= p;
            end
            if (valid_reg[p] && seq_reg[p] == prev && !old_f_reg)
            begin
                old_f_reg <= 1'b1;
                old_reg   <= p;
            end
            if (!valid_reg[p] && !free_f_reg)
            begin
                free_f_reg <= 1'b1;
                free_reg   <= p;
            end
            if (st_reg[p] < oldest_t_reg)
            begin
                oldest_t_reg <= st_reg[p];
                oldest_reg   <= p;
            end
            if (valid_reg[p] && comp_reg[p] && dt_reg[p] > best_t_reg)
            begin
                best_t_reg <= dt_reg[p];
                best_f_reg <= 1'b1;
                best_reg   <= p;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/phase_exchange_entry_table_top.sv =====
// Path from accept to result: input queue, slot scan (one slot a cycle), then the apply step that registers the result.
// The engine handles one word at a time and takes the next only once the result is taken.
// A two-word input queue accepts while it has room, also while the engine works; result is held until taken.
// Config is accepted only while the engine and queue are empty.
// Reset (rst_n, async low) clears the table, is_master and all handshake state.
`default_nettype none
module phase_exchange_entry_table_top #(
    parameter int ENTRIES = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pete_cfg_if.sink   cfg,
    pete_in_if.sink    in_ch,
    pete_out_if.source out_ch
);
    import pete_pkg::*;

    in_word_t q_data;
    logic     q_valid, q_pop, busy;
    logic     is_master_reg;

    assign cfg.ready = !busy && !q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_master_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            is_master_reg <= cfg.is_master;
        end
    end

    pete_front u_front (
        .clk, .rst_n, .in_ch, .q_data, .q_valid, .q_pop
    );

    pete_back #(.ENTRIES(ENTRIES)) u_back (
        .clk, .rst_n, .is_master(is_master_reg), .q_data, .q_valid, .q_pop,
        .out_ch, .busy
    );
endmodule
`default_nettype wire

// ===== sv/pete_checker.sv =====
`default_nettype none
module pete_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_hit,
    input wire logic [3:0] out_index,
    input wire logic [31:0] out_phase
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_miss_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_hit |-> out_index == 4'd0)
        else $error("index set on miss");
    a_miss_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_hit |-> out_phase == 32'd0)
        else $error("phase set on miss");
endmodule

bind phase_exchange_entry_table_top pete_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_hit(out_ch.data.hit), .out_index(out_ch.data.entry_index),
    .out_phase(out_ch.data.phase_out)
);
`default_nettype wire
